FILE: design/kxss_pkg.sv
// Shared types and constants for the keyed XOR stream scrambler.
package kxss_pkg;

  localparam int unsigned TEXT_DEPTH = 1024;
  localparam int unsigned MSG_BYTES  = 16384;

  localparam int unsigned TEXT_AW = $clog2(TEXT_DEPTH);
  localparam int unsigned TEXT_LW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(MSG_BYTES) + 1;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_PAYLOAD = 2'd3
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [7:0]       data_byte;
    logic [31:0]      seed;
    logic [IDX_W-1:0] clear_bytes;
    logic             end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic       rewind;
    logic       fetch;
    logic [7:0] ch;
  } text_req_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] ch;
  } text_rsp_t;

endpackage

FILE: design/kxss_text.sv
// Key text store: character memory, fill length and wrapping read position.
module kxss_text (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kxss_pkg::text_req_t req_i,
  output kxss_pkg::text_rsp_t rsp_o
);
  import kxss_pkg::*;

  logic [7:0]         mem [TEXT_DEPTH];
  logic [TEXT_LW-1:0] len_q, len_d;
  logic [TEXT_LW-1:0] pos_q, pos_d;
  logic [TEXT_LW-1:0] rd_pos;
  logic               wr_en;
  logic               rd_en;
  logic [7:0]         rdata_q;
  logic               empty_q;

  always_comb begin
    len_d  = len_q;
    pos_d  = pos_q;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    rd_pos = (pos_q >= len_q) ? '0 : pos_q;
    if (req_i.clear) begin
      len_d = '0;
      pos_d = '0;
    end
    if (req_i.append && (req_i.ch != 8'd0) && (len_q < TEXT_LW'(TEXT_DEPTH))) begin
      wr_en = 1'b1;
      len_d = len_q + TEXT_LW'(1);
    end
    if (req_i.rewind) begin
      pos_d = '0;
    end
    if (req_i.fetch) begin
      rd_en = 1'b1;
      if (len_q != '0) begin
        pos_d = rd_pos + TEXT_LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
    end else begin
      len_q <= len_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[TEXT_AW-1:0]] <= req_i.ch;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_pos[TEXT_AW-1:0]];
      empty_q <= (len_q == '0);
    end
  end

  assign rsp_o.empty = empty_q;
  assign rsp_o.ch    = rdata_q;

endmodule

FILE: design/keyed_xor_stream_scrambler_unit.sv
// Top level of the keyed XOR stream scrambler.
// Takes one beat per clock cycle while in_stall_o is low, and returns one output beat
// per payload beat, which passes through the position stage registers and then the
// output register before out_valid_o rises; clear, append and start beats return nothing.
// The key text memory has a synchronous read, which separates the position stage
// from the key update stage. The text store needs no clearing pass after reset,
// and the challenge register may be written when idle.
module keyed_xor_stream_scrambler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kxss_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kxss_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);
  import kxss_pkg::*;

  logic [31:0]      challenge_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]       key_q, key_d;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_start_q;
  logic             s1_pass_q;
  logic             s1_par_q;
  logic [7:0]       s1_data_q;
  logic             s1_eom_q;
  logic [7:0]       s1_key_q;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;

  text_req_t        treq;
  text_rsp_t        trsp;

  logic             accept;
  logic             out_ready;
  logic             s1_go;
  logic             s1_ready;
  logic             in_clear;
  logic [7:0]       ch_raw;
  logic [7:0]       ch;
  logic [7:0]       mix;
  logic [7:0]       key_new;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (s1_start_q || out_ready);
  assign s1_ready   = !s1_valid_q || s1_go;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;
  assign in_clear   = idx_q < clr_cnt_q;

  always_comb begin
    treq        = '0;
    treq.ch     = in_item_i.data_byte;
    idx_d       = idx_q;
    clr_cnt_d   = clr_cnt_q;
    s1_valid_d  = s1_valid_q && !s1_go;
    if (accept) begin
      case (in_item_i.func)
        FUNC_CLEAR: begin
          treq.clear = 1'b1;
        end
        FUNC_APPEND: begin
          treq.append = 1'b1;
        end
        FUNC_START: begin
          treq.rewind = 1'b1;
          idx_d       = '0;
          clr_cnt_d   = in_item_i.clear_bytes;
          s1_valid_d  = 1'b1;
        end
        FUNC_PAYLOAD: begin
          treq.fetch = !in_clear;
          idx_d      = idx_q + IDX_W'(1);
          s1_valid_d = 1'b1;
        end
        default: begin
          treq = '0;
        end
      endcase
    end
  end

  kxss_text u_text (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (treq),
    .rsp_o  (trsp)
  );

  always_comb begin
    ch_raw  = trsp.empty ? 8'd0 : trsp.ch;
    ch      = (ch_raw == CHAR_PERCENT) ? CHAR_DOT : ch_raw;
    mix     = s1_par_q ? {ch[6:0], 1'b0} : ch;
    key_new = key_q ^ mix;
    key_d   = key_q;
    if (s1_go) begin
      if (s1_start_q) begin
        key_d = s1_key_q;
      end else if (!s1_pass_q) begin
        key_d = key_new;
      end
    end
    out_valid_d = out_ready ? (s1_go && !s1_start_q) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      challenge_q <= '0;
      idx_q       <= '0;
      clr_cnt_q   <= '0;
      key_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        challenge_q <= cfg_wdata_i;
      end
      idx_q       <= idx_d;
      clr_cnt_q   <= clr_cnt_d;
      key_q       <= key_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_start_q <= (in_item_i.func == FUNC_START);
      s1_pass_q  <= in_clear;
      s1_par_q   <= idx_q[0];
      s1_data_q  <= in_item_i.data_byte;
      s1_eom_q   <= in_item_i.end_of_message;
      s1_key_q   <= challenge_q[7:0] ^ in_item_i.seed[7:0];
    end
    if (out_ready && s1_go && !s1_start_q) begin
      out_item_q.out_byte   <= s1_pass_q ? s1_data_q : (s1_data_q ^ key_new);
      out_item_q.final_byte <= s1_eom_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
